// ===== hw/rtl/theap_pkg.sv =====
`default_nettype none
package theap_pkg;

    // Operation codes carried on the input stream.
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Result kinds.
    localparam logic [2:0] EV_ADDED     = 3'd0;
    localparam logic [2:0] EV_FULL      = 3'd1;
    localparam logic [2:0] EV_REMOVED   = 3'd2;
    localparam logic [2:0] EV_NOT_FOUND = 3'd3;
    localparam logic [2:0] EV_FIRED     = 3'd4;
    localparam logic [2:0] EV_DONE      = 3'd5;

    // One heap slot: deadline, id, interval and repeat flag.
    typedef struct packed {
        logic [63:0] deadline;
        logic [7:0]  timer_id;
        logic [31:0] interval;
        logic        repeat_flag;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  timer_id;
        logic [63:0] fire_time;
        logic        last;
    } t_event;

    // Saturating 64-bit add of a 32-bit value.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/theap_out_reg.sv =====
`default_nettype none
module theap_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  theap_pkg::t_event    i_event,
    output logic                 o_full,
    output logic                 o_tvalid,
    input  wire                  i_tready,
    output theap_pkg::t_event    o_event
);
    import theap_pkg::*;

    logic   r_valid;
    t_event r_event;

    // Single output register; the core pushes only when it is free or taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_event <= i_event;
        end
    end

    assign o_full   = r_valid && !i_tready;
    assign o_tvalid = r_valid;
    assign o_event  = r_event;
endmodule
`default_nettype wire

// ===== hw/rtl/timer_event_heap_scheduler_core.sv =====
`default_nettype none
// Binary min-heap of up to HEAP_DEPTH software timers keyed by a 64-bit absolute
// deadline, held in one synchronous memory with a registered read and a separate
// write port. Items are handled one at a time: the input is ready only in idle,
// that is after the last result of the previous item has entered the single
// output register. An add sifts the new timer upward, reading and comparing one
// parent per level, then writes it into its slot; on a full heap it only reports
// full. A remove scans the entries one at a time up to the match (or to the end
// for a missing id), then, unless the match was the last entry, moves the last
// entry into the gap and re-sifts it upward and then downward. An advance checks
// the root; each firing adds a pop read, a sift-down, a write-back, for a
// repeating timer an add-like sift, and the hand-over of its result. Each result
// waits while the output register still holds an untaken one. The memory is not
// cleared after reset; only the first entry-count slots are ever read as data.
module timer_event_heap_scheduler_core #(
    parameter int HEAP_DEPTH            = 64,
    parameter int MAX_FIRES_PER_ADVANCE = 63
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0]
    input  wire  [1:0]   s_axis_tuser,
    // timer_id[7:0], delay_ticks[39:8], interval_ticks[71:40], repeat_req[72],
    // elapsed_ticks[104:73], zero fill up to 111
    input  wire  [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // event_kind[2:0]
    output logic [2:0]   m_axis_tuser,
    // event_timer_id[7:0], fire_time[71:8]
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import theap_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_CHK, S_LAST_GET, S_UP, S_UP_CMP, S_DN, S_DN_L, S_DN_R,
        S_WB, S_ROOT, S_ROOT_CHK, S_POP_GET, S_EMIT
    } t_state;

    function automatic t_event make_event(input logic [2:0] kind, input logic [7:0] id,
                                          input logic [63:0] t, input logic last);
        t_event e;
        e.kind      = kind;
        e.timer_id  = id;
        e.fire_time = t;
        e.last      = last;
        return e;
    endfunction

    function automatic t_entry make_entry(input logic [63:0] dl, input logic [7:0] id,
                                          input logic [31:0] iv, input logic rp);
        t_entry e;
        e.deadline    = dl;
        e.timer_id    = id;
        e.interval    = iv;
        e.repeat_flag = rp;
        return e;
    endfunction

    // Heap storage.
    t_entry        mem [HEAP_DEPTH];
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    t_entry        wr_data;
    t_entry        r_rdata;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [63:0]   r_now;
    logic [1:0]    r_op;
    logic [7:0]    r_id;
    logic [AW-1:0] r_pos;       // hole that the sifted entry currently occupies
    logic [CW-1:0] r_scan;
    t_entry        r_node;      // entry being sifted
    t_entry        r_left;
    logic [KW-1:0] r_fires;
    t_entry        r_fired;
    logic          r_reins;     // reinsertion of a repeating timer in progress
    t_event        r_ev;

    logic          push;
    logic          out_full;
    t_event        out_ev;

    // Input fields.
    logic [1:0]    in_op;
    logic [7:0]    in_id;
    logic [31:0]   in_delay, in_iv, in_el;
    logic          in_rp;
    logic [31:0]   add_delay, add_iv;

    // Heap navigation.
    logic [AW-1:0] parent_pos;
    logic [AW:0]   lc_w;
    logic [AW+1:0] rc_w;
    logic [AW+1:0] count_x;
    logic          lc_ok;
    logic          rc_ok;
    logic          pick_right;
    t_entry        pick;
    logic [AW-1:0] pick_pos;
    logic [AW-1:0] last_pos;

    // Memory with one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    theap_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_event(r_ev),
        .o_full(out_full), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_event(out_ev)
    );

    assign m_axis_tuser  = out_ev.kind;
    assign m_axis_tdata  = {out_ev.fire_time, out_ev.timer_id};
    assign m_axis_tlast  = out_ev.last;
    assign s_axis_tready = (r_state == S_IDLE);
    assign push          = (r_state == S_EMIT) && !out_full;

    assign in_op     = s_axis_tuser;
    assign in_id     = s_axis_tdata[7:0];
    assign in_delay  = s_axis_tdata[39:8];
    assign in_iv     = s_axis_tdata[71:40];
    assign in_rp     = s_axis_tdata[72];
    assign in_el     = s_axis_tdata[104:73];
    assign add_delay = (in_delay == 32'd0) ? 32'd1 : in_delay;
    assign add_iv    = (in_iv == 32'd0) ? 32'd1 : in_iv;

    // Parent and children of the hole; the right child wins only when strictly earlier.
    assign parent_pos = (r_pos - AW'(1)) >> 1;
    assign lc_w       = {r_pos, 1'b1};
    assign rc_w       = {1'b0, lc_w} + (AW+2)'(1);
    assign count_x    = (AW+2)'(r_count);
    assign lc_ok      = {1'b0, lc_w} < count_x;
    assign rc_ok      = rc_w < count_x;
    assign pick_right = rc_ok && (r_rdata.deadline < r_left.deadline);
    assign pick       = pick_right ? r_rdata : r_left;
    assign pick_pos   = pick_right ? rc_w[AW-1:0] : lc_w[AW-1:0];
    assign last_pos   = AW'(r_count - CW'(1));

    // Memory addresses and write-back for each state.
    always_comb begin
        rd_addr = r_pos;
        wr_addr = r_pos;
        wr_en   = 1'b0;
        wr_data = r_node;
        case (r_state)
            S_SCAN:     rd_addr = r_scan[AW-1:0];
            S_SCAN_CHK: rd_addr = last_pos;
            S_UP:       rd_addr = parent_pos;
            S_UP_CMP: begin
                wr_en   = r_node.deadline < r_rdata.deadline;
                wr_data = r_rdata;
            end
            S_DN:       rd_addr = lc_w[AW-1:0];
            S_DN_L:     rd_addr = rc_w[AW-1:0];
            S_DN_R: begin
                wr_en   = pick.deadline < r_node.deadline;
                wr_data = pick;
            end
            S_WB:       wr_en = 1'b1;
            S_ROOT:     rd_addr = '0;
            S_ROOT_CHK: rd_addr = last_pos;
            default:    rd_addr = r_pos;
        endcase
    end

    // Control: accept, scan, sift up then down, pop and emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_now   <= '0;
            r_fires <= '0;
            r_reins <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= in_op;
                        r_id    <= in_id;
                        r_reins <= 1'b0;
                        case (in_op)
                            OP_ADD: begin
                                if (r_count == CW'(HEAP_DEPTH)) begin
                                    r_ev    <= make_event(EV_FULL, in_id, '0, 1'b1);
                                    r_state <= S_EMIT;
                                end else begin
                                    r_node  <= make_entry(sat_add(r_now, add_delay),
                                                          in_id, add_iv, in_rp);
                                    r_pos   <= AW'(r_count);
                                    r_count <= r_count + CW'(1);
                                    r_state <= S_UP;
                                end
                            end
                            OP_REMOVE: begin
                                r_scan  <= '0;
                                r_state <= S_SCAN;
                            end
                            OP_ADVANCE: begin
                                r_now   <= sat_add(r_now, in_el);
                                r_fires <= '0;
                                r_state <= S_ROOT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // Linear id search: read one entry, compare it in the next cycle.
                S_SCAN: begin
                    if (r_scan == r_count) begin
                        r_ev    <= make_event(EV_NOT_FOUND, r_id, '0, 1'b1);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (r_rdata.timer_id == r_id) begin
                        r_pos   <= r_scan[AW-1:0];
                        r_count <= r_count - CW'(1);
                        if (r_scan == r_count - CW'(1)) begin
                            r_ev    <= make_event(EV_REMOVED, r_id, '0, 1'b1);
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_LAST_GET;
                        end
                    end else begin
                        r_scan  <= r_scan + CW'(1);
                        r_state <= S_SCAN;
                    end
                end
                // The last entry fills the gap left by the removed one.
                S_LAST_GET: begin
                    r_node  <= r_rdata;
                    r_state <= S_UP;
                end
                S_UP: r_state <= (r_pos == '0) ? S_DN : S_UP_CMP;
                S_UP_CMP: begin
                    if (r_node.deadline < r_rdata.deadline) begin
                        r_pos   <= parent_pos;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_DN;
                    end
                end
                S_DN: r_state <= lc_ok ? S_DN_L : S_WB;
                S_DN_L: begin
                    r_left  <= r_rdata;
                    r_state <= S_DN_R;
                end
                S_DN_R: begin
                    if (pick.deadline < r_node.deadline) begin
                        r_pos   <= pick_pos;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                // The sifted entry lands in the hole; decide what follows.
                S_WB: begin
                    case (r_op)
                        OP_ADD: begin
                            r_ev    <= make_event(EV_ADDED, r_id, '0, 1'b1);
                            r_state <= S_EMIT;
                        end
                        OP_REMOVE: begin
                            r_ev    <= make_event(EV_REMOVED, r_id, '0, 1'b1);
                            r_state <= S_EMIT;
                        end
                        OP_ADVANCE: begin
                            if (!r_reins && r_fired.repeat_flag) begin
                                r_reins <= 1'b1;
                                r_node  <= make_entry(sat_add(r_now, r_fired.interval),
                                                      r_fired.timer_id, r_fired.interval,
                                                      1'b1);
                                r_pos   <= AW'(r_count);
                                r_count <= r_count + CW'(1);
                                r_state <= S_UP;
                            end else begin
                                r_reins <= 1'b0;
                                r_ev    <= make_event(EV_FIRED, r_fired.timer_id,
                                                      r_fired.deadline, 1'b0);
                                r_state <= S_EMIT;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ROOT: r_state <= S_ROOT_CHK;
                // Pop an expired root, or finish the advance.
                S_ROOT_CHK: begin
                    if (r_count != '0 && r_rdata.deadline <= r_now &&
                        r_fires != KW'(MAX_FIRES_PER_ADVANCE)) begin
                        r_fired <= r_rdata;
                        r_fires <= r_fires + KW'(1);
                        r_count <= r_count - CW'(1);
                        r_state <= S_POP_GET;
                    end else begin
                        r_ev    <= make_event(EV_DONE, '0, r_now, 1'b1);
                        r_state <= S_EMIT;
                    end
                end
                S_POP_GET: begin
                    r_node  <= r_rdata;
                    r_pos   <= '0;
                    r_state <= S_DN;
                end
                S_EMIT: begin
                    if (!out_full) begin
                        r_state <= (r_ev.kind == EV_FIRED) ? S_ROOT : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata, m_axis_tlast}))
        else $error("result changed while stalled");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH))
        else $error("entry count overflow");
    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fires <= KW'(MAX_FIRES_PER_ADVANCE))
        else $error("fire cap exceeded");
`endif
endmodule
`default_nettype wire
